FILE: rtl/core/tksel_pkg.sv
// Package for the top-K largest selector: state enum, command and status structs,
// and fixed field widths. Depends on nothing.
`default_nettype none
package tksel_pkg;

  localparam int VALUE_W    = 32;
  localparam int RANK_W     = 4;
  localparam int KEEP_CFG_W = 5;
  localparam logic [KEEP_CFG_W-1:0] KEEP_RESET = 5'd10;

  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_EMIT
  } tksel_state_t;

  typedef struct packed {
    logic insert;   // shift the input value into the row
    logic capture;  // latch the report count and clear the rank counter
    logic load;     // move the head of the row into the output register
  } tksel_cmd_t;

  typedef struct packed {
    logic last_pending;  // the next load is the final result of the set
    logic out_busy;      // output register holds a result that is not taken
  } tksel_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/tksel_ctrl.sv
// Controller for the top-K largest selector: collect / emit state machine.
// Depends on tksel_pkg.
`default_nettype none
module tksel_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                last,
  output logic                     in_ready,
  input  wire tksel_pkg::tksel_sts_t sts,
  output tksel_pkg::tksel_cmd_t    cmd
);

  tksel_pkg::tksel_state_t state;
  tksel_pkg::tksel_state_t state_next;
  logic in_fire;

  assign in_ready = (state == tksel_pkg::ST_COLLECT);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tksel_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tksel_pkg::ST_COLLECT: begin
        if (in_fire && last) begin
          state_next = tksel_pkg::ST_EMIT;
        end
      end
      tksel_pkg::ST_EMIT: begin
        if (!sts.out_busy && sts.last_pending) begin
          state_next = tksel_pkg::ST_COLLECT;
        end
      end
      default: state_next = tksel_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      tksel_pkg::ST_COLLECT: begin
        cmd.insert  = in_fire;
        cmd.capture = in_fire && last;
      end
      tksel_pkg::ST_EMIT: begin
        cmd.load = !sts.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/tksel_datapath.sv
// Datapath for the top-K largest selector: sorted shift-insert row of compare
// cells, keep count register, rank counter and output register. Depends on tksel_pkg.
`default_nettype none
module tksel_datapath #(
  parameter int KEEP_MAX = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire tksel_pkg::tksel_cmd_t                  cmd,
  output tksel_pkg::tksel_sts_t                       sts,
  input  wire logic signed [tksel_pkg::VALUE_W-1:0]   value,
  input  wire logic                                   cfg_we,
  input  wire logic [tksel_pkg::KEEP_CFG_W-1:0]       cfg_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [tksel_pkg::VALUE_W-1:0]        value_res,
  output logic [tksel_pkg::RANK_W-1:0]                rank,
  output logic                                        final_res
);

  localparam int VW = tksel_pkg::VALUE_W;
  localparam int RW = tksel_pkg::RANK_W;
  localparam int CFGW = tksel_pkg::KEEP_CFG_W;
  localparam int CW = $clog2(KEEP_MAX + 1);
  localparam int KW = (CW > CFGW) ? CW : CFGW;

  logic signed [VW-1:0] entry [KEEP_MAX];
  logic signed [VW-1:0] entry_ins [KEEP_MAX];
  logic [KEEP_MAX-1:0]  ge;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_ins;
  logic [CFGW-1:0]      keep_count;
  logic [KW-1:0]        k_eff;
  logic [KW-1:0]        n_wide;
  logic [CW-1:0]        n_q;
  logic [CW-1:0]        idx;

  // compare cells: ge is a thermometer over the valid prefix
  for (genvar i = 0; i < KEEP_MAX; i++) begin : g_cell
    assign ge[i] = (CW'(i) < count) && (entry[i] >= value);
    if (i == 0) begin : g_head
      assign entry_ins[i] = ge[i] ? entry[i] : value;
    end else begin : g_body
      assign entry_ins[i] = ge[i] ? entry[i] : (ge[i-1] ? value : entry[i-1]);
    end
  end

  assign count_ins = (count == CW'(KEEP_MAX)) ? count : count + CW'(1);

  always_comb begin
    k_eff = KW'(keep_count);
    if (k_eff == '0) begin
      k_eff = KW'(1);
    end else if (k_eff > KW'(KEEP_MAX)) begin
      k_eff = KW'(KEEP_MAX);
    end
    n_wide = (KW'(count_ins) < k_eff) ? KW'(count_ins) : k_eff;
  end

  assign sts.last_pending = ({1'b0, idx} + (CW + 1)'(1)) == {1'b0, n_q};
  assign sts.out_busy     = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= tksel_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      keep_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count_ins;
    end else if (cmd.load && sts.last_pending) begin
      count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < KEEP_MAX; i++) begin
        entry[i] <= entry_ins[i];
      end
    end else if (cmd.load) begin
      for (int i = 0; i < KEEP_MAX - 1; i++) begin
        entry[i] <= entry[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n_q <= CW'(n_wide);
      idx <= '0;
    end else if (cmd.load) begin
      idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_res <= entry[0];
      rank      <= RW'(idx);
      final_res <= sts.last_pending;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/top_k_largest_selector_core.sv
// Top level of the top-K largest selector: controller plus datapath.
// Depends on tksel_pkg, tksel_ctrl, tksel_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready, value, last) takes one signed value per
//   transaction. Every value is inserted into a sorted row of KEEP_MAX cells as
//   it is taken, so a data set streams in at one value per cycle.
//   The value marked last is inserted, then the block emits the kept values
//   from largest down on the output channel (out_valid/out_ready, value_res,
//   rank, final_res), min(loaded, keep_count) results, one per cycle when the
//   receiver is ready; final_res marks the last one. The first result is loaded
//   once the state has moved to emission and the output register is free.
//   in_ready is low during emission; it rises as the final result is loaded, so
//   the next set may start while that result still waits in the output register.
//   A stalled receiver holds the output register and pauses emission.
//   Config channel (cfg_valid/cfg_ready, cfg_data) writes keep_count;
//   0 acts as 1, values above KEEP_MAX act as KEEP_MAX. Write it only while idle.
//   Reset empties the row, drops any pending output and sets keep_count to 10.
`default_nettype none
module top_k_largest_selector_core #(
  parameter int KEEP_MAX = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [tksel_pkg::VALUE_W-1:0] value,
  input  wire logic                                 last,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [tksel_pkg::VALUE_W-1:0]      value_res,
  output logic [tksel_pkg::RANK_W-1:0]              rank,
  output logic                                      final_res,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tksel_pkg::KEEP_CFG_W-1:0]     cfg_data
);

  tksel_pkg::tksel_cmd_t cmd;
  tksel_pkg::tksel_sts_t sts;

  assign cfg_ready = 1'b1;

  tksel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tksel_datapath #(
    .KEEP_MAX (KEEP_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_res (value_res),
    .rank      (rank),
    .final_res (final_res)
  );

endmodule
`default_nettype wire

FILE: rtl/core/tksel_checker.sv
// Port-level checker for top_k_largest_selector_core, attached by bind.
// Depends on tksel_pkg and the top level's ports.
`default_nettype none
module tksel_props (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 last,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [tksel_pkg::VALUE_W-1:0] value_res,
  input wire logic [tksel_pkg::RANK_W-1:0]         rank,
  input wire logic                                 final_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_res) && $stable(rank)
      && $stable(final_res))
    else $error("output transaction changed while stalled");

  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("input taken during emission");

  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !final_res |=> out_valid && rank == $past(rank) + 4'd1)
    else $error("rank sequence broken");

  a_first_rank: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> rank == 4'd0)
    else $error("set does not start at rank zero");

  // input reopens when the final result of a set is loaded
  a_final_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid && final_res) |-> in_ready)
    else $error("input blocked after final result");

endmodule

bind top_k_largest_selector_core tksel_props u_tksel_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value_res (value_res),
  .rank      (rank),
  .final_res (final_res)
);
`default_nettype wire

FILE: test/tksel_checker.sv
// Checker for the top-K largest selector: watches the input, output and config
// channels, tracks the kept row and report count, and compares every result.
// Depends on tksel_pkg.
module tksel_checker #(
  parameter int KEEP_MAX = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [tksel_pkg::VALUE_W-1:0] value,
  input  logic                                 last,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [tksel_pkg::VALUE_W-1:0] value_res,
  input  logic [tksel_pkg::RANK_W-1:0]         rank,
  input  logic                                 final_res,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [tksel_pkg::KEEP_CFG_W-1:0]     cfg_data,
  output int                                   fail_count,
  output int                                   pending_results
);

  typedef struct packed {
    logic signed [tksel_pkg::VALUE_W-1:0] value;
    logic [tksel_pkg::RANK_W-1:0]         rank;
    logic                                 is_last;
  } ranked_t;

  logic signed [tksel_pkg::VALUE_W-1:0] top_row [KEEP_MAX];
  int                                   row_len;
  logic [tksel_pkg::KEEP_CFG_W-1:0]     keep_cfg;
  ranked_t                              ranked_q [$];

  // descending row, a new value goes behind equal ones, smallest falls off
  task automatic insert_sorted(input logic signed [tksel_pkg::VALUE_W-1:0] v);
    int pos;
    int i;
    pos = 0;
    while (pos < row_len && top_row[pos] >= v) pos++;
    if (pos < KEEP_MAX) begin
      i = (row_len < KEEP_MAX) ? row_len : KEEP_MAX - 1;
      while (i > pos) begin
        top_row[i] = top_row[i-1];
        i--;
      end
      top_row[pos] = v;
      if (row_len < KEEP_MAX) row_len++;
    end
  endtask

  task automatic report_set();
    int k;
    int n;
    ranked_t r;
    k = keep_cfg;
    if (k == 0) k = 1;
    if (k > KEEP_MAX) k = KEEP_MAX;
    n = (row_len < k) ? row_len : k;
    for (int i = 0; i < n; i++) begin
      r.value   = top_row[i];
      r.rank    = i[tksel_pkg::RANK_W-1:0];
      r.is_last = (i == n - 1);
      ranked_q.push_back(r);
    end
    for (int i = 0; i < KEEP_MAX; i++) top_row[i] = '0;
    row_len = 0;
  endtask

  always @(posedge clk) begin
    ranked_t want;
    if (rst) begin
      for (int i = 0; i < KEEP_MAX; i++) top_row[i] = '0;
      row_len  = 0;
      keep_cfg = tksel_pkg::KEEP_RESET;
      ranked_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (ranked_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result value=%0d rank=%0d last=%0b", $time,
                     value_res, rank, final_res);
          fail_count++;
        end else begin
          want = ranked_q.pop_front();
          if (want.value !== value_res || want.rank !== rank ||
              want.is_last !== final_res) begin
            if (fail_count < 10)
              $display({"%0t: mismatch, expected value=%0d rank=%0d last=%0b, ",
                        "got value=%0d rank=%0d last=%0b"},
                       $time, want.value, want.rank, want.is_last,
                       value_res, rank, final_res);
            fail_count++;
          end
        end
      end
      // a transaction sees the keep count from before a write on the same edge
      if (in_valid && in_ready) begin
        insert_sorted(value);
        if (last) report_set();
      end
      if (cfg_valid && cfg_ready) keep_cfg = cfg_data;
    end
    pending_results = ranked_q.size();
  end

endmodule

FILE: test/tb_top_k_largest_selector_core.sv
// Testbench top for the top-K largest selector: clock, reset, stimulus on the
// input, output and config channels, and the verdict.
// Depends on tksel_pkg, top_k_largest_selector_core and tksel_checker.
module tb_top_k_largest_selector_core;

  localparam int KEEP_MAX    = 16;
  localparam int RANDOM_ITEMS = 360;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE      = 4;
  localparam int DRAIN       = 20;
  localparam int VW          = tksel_pkg::VALUE_W;
  localparam int RW          = tksel_pkg::RANK_W;
  localparam int CFG_W       = tksel_pkg::KEEP_CFG_W;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [VW-1:0]  value;
  logic                  last;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [VW-1:0]  value_res;
  logic [RW-1:0]         rank;
  logic                  final_res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;

  int   fail_count;
  int   pending_results;
  int   send_idle;
  int   recv_idle;
  logic hold_req;

  top_k_largest_selector_core #(
    .KEEP_MAX(KEEP_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .last     (last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value_res(value_res),
    .rank     (rank),
    .final_res(final_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  tksel_checker #(
    .KEEP_MAX(KEEP_MAX)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .value          (value),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value_res      (value_res),
    .rank           (rank),
    .final_res      (final_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off once requested
  initial begin
    int hold_cnt;
    hold_cnt  = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        out_ready = 1'b0;
        hold_cnt++;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(input logic signed [VW-1:0] v, input logic is_last);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    value    = v;
    last     = is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_keep(input logic [CFG_W-1:0] k);
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [VW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed($urandom_range(6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_keep();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(KEEP_MAX);
      3:       return '1;
      default: return CFG_W'($urandom_range(31));
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    bit after_hold;
    rst        = 1'b1;
    in_valid   = 1'b0;
    value      = '0;
    last       = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    send_idle  = 0;
    recv_idle  = 0;
    hold_req   = 1'b0;
    after_hold = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default keep count, single-value set
    send_item(0, 1'b1);
    // fewer values than kept, extremes and duplicates
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b1);
    // zero keep count acts as one
    write_keep('0);
    send_item(5, 1'b0);
    send_item(-7, 1'b0);
    send_item(5, 1'b1);
    // keep count changed inside a set
    write_keep(CFG_W'(KEEP_MAX));
    send_item(100, 1'b0);
    send_item(-100, 1'b0);
    send_item(50, 1'b0);
    write_keep(CFG_W'(2));
    send_item(75, 1'b1);
    // saturating keep counts
    write_keep('1);
    repeat (3) send_item(42, 1'b0);
    send_item(42, 1'b1);
    write_keep(CFG_W'(KEEP_MAX + 1));
    send_item(-3, 1'b0);
    send_item(32'sh5555_AAAA, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle = 22; recv_idle = 76; end
        1:       begin send_idle = 76; recv_idle = 22; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        if (phase == 2 && !hold_req) begin
          write_keep(CFG_W'(KEEP_MAX));
          len        = 20;
          after_hold = 1'b1;
        end else begin
          // the set after the hold-off keeps pushing into the stalled block
          if (!after_hold && $urandom_range(3) == 0) write_keep(pick_keep());
          after_hold = 1'b0;
          len = ($urandom_range(7) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 12);
        end
        for (int i = 0; i < len; i++) begin
          // long receiver hold-off while the next set keeps pushing
          if (phase == 2 && !hold_req && i == len - 1) hold_req = 1'b1;
          send_item(pick_value(), i == len - 1);
        end
        sent += len;
      end
    end
    in_valid = 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
